@@ rtl/mxi_pkg.sv @@
// Package for the 3x3 matrix inverse core.
// Holds the control struct that travels beside the datapath.
// No dependencies.
package mxi_pkg;

  // Control that travels with each item down the pipeline
  typedef struct packed {
    logic vld;
    logic sing;
  } mxi_ctl_t;

  // Number of register stages in the front end (products .. abs)
  localparam int FRONT_STAGES = 6;

endpackage

@@ rtl/matrix3x3_inverse_core.sv @@
// Top level of the 3x3 matrix inverse core (adjugate over determinant).
// Uses mxi_pkg, mxi_front and mxi_div.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+------------------------
//  input   | in_m00 .. in_m22                       | start high, busy low
//  result  | out_inv00 .. out_inv22, out_determinant | out_strobe, one cycle
//          | out_singular                           |
//
// One item per cycle; six front-end stages
// (products, cofactors, two for the split determinant products, sum, magnitudes)
// then DATA_WIDTH + 2 divider stages (input, one per quotient bit, output).
// busy stays low; results are never held back. Synchronous reset clears
// the valid bits only, so items in flight at reset are dropped.
module matrix3x3_inverse_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_m00,
  input  logic signed [DATA_WIDTH-1:0] in_m01,
  input  logic signed [DATA_WIDTH-1:0] in_m02,
  input  logic signed [DATA_WIDTH-1:0] in_m10,
  input  logic signed [DATA_WIDTH-1:0] in_m11,
  input  logic signed [DATA_WIDTH-1:0] in_m12,
  input  logic signed [DATA_WIDTH-1:0] in_m20,
  input  logic signed [DATA_WIDTH-1:0] in_m21,
  input  logic signed [DATA_WIDTH-1:0] in_m22,
  output logic                         out_strobe,
  output logic signed [DATA_WIDTH-1:0] out_inv00,
  output logic signed [DATA_WIDTH-1:0] out_inv01,
  output logic signed [DATA_WIDTH-1:0] out_inv02,
  output logic signed [DATA_WIDTH-1:0] out_inv10,
  output logic signed [DATA_WIDTH-1:0] out_inv11,
  output logic signed [DATA_WIDTH-1:0] out_inv12,
  output logic signed [DATA_WIDTH-1:0] out_inv20,
  output logic signed [DATA_WIDTH-1:0] out_inv21,
  output logic signed [DATA_WIDTH-1:0] out_inv22,
  output logic signed [DATA_WIDTH-1:0] out_determinant,
  output logic                         out_singular
);
  import mxi_pkg::*;

  localparam int W       = DATA_WIDTH;
  localparam int CW      = 2 * W + 1;
  localparam int DW      = 3 * W + 3;
  localparam int DIV_LAT = W + 2;

  logic signed [W-1:0] m [9];
  mxi_ctl_t            f_ctl;
  logic [DW-1:0]       f_det_mag;
  logic                f_det_neg;
  logic [W-1:0]        f_det_q;
  logic [CW-1:0]       f_cof_mag [9];
  logic                f_cof_neg [9];
  logic [W-1:0]        q [9];
  logic [W-1:0]        res [9];

  mxi_ctl_t            ctl_p_r  [DIV_LAT];
  logic [W-1:0]        detq_p_r [DIV_LAT];

  assign busy = 1'b0;

  assign m[0] = in_m00;
  assign m[1] = in_m01;
  assign m[2] = in_m02;
  assign m[3] = in_m10;
  assign m[4] = in_m11;
  assign m[5] = in_m12;
  assign m[6] = in_m20;
  assign m[7] = in_m21;
  assign m[8] = in_m22;

  mxi_front #(.W(W), .F(FRAC_BITS), .CW(CW), .DW(DW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_i     (start && !busy),
    .m_i       (m),
    .ctl_o     (f_ctl),
    .det_mag_o (f_det_mag),
    .det_neg_o (f_det_neg),
    .det_q_o   (f_det_q),
    .cof_mag_o (f_cof_mag),
    .cof_neg_o (f_cof_neg)
  );

  // inverse entry (i,j) takes cofactor (j,i)
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      mxi_div #(.W(W), .F(FRAC_BITS), .CW(CW), .DW(DW)) u_div (
        .clk   (clk),
        .num_i (f_cof_mag[j*3+i]),
        .den_i (f_det_mag),
        .neg_i (f_cof_neg[j*3+i] ^ f_det_neg),
        .q_o   (q[i*3+j])
      );
    end
  end

  // side line matching the divider latency; reset clears the valid bits only
  always_ff @(posedge clk) begin
    ctl_p_r[0].sing <= f_ctl.sing;
    detq_p_r[0]     <= f_det_q;
    for (int k = 1; k < DIV_LAT; k++) begin
      ctl_p_r[k].sing <= ctl_p_r[k-1].sing;
      detq_p_r[k]     <= detq_p_r[k-1];
    end
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        ctl_p_r[k].vld <= 1'b0;
      end
    end else begin
      ctl_p_r[0].vld <= f_ctl.vld;
      for (int k = 1; k < DIV_LAT; k++) begin
        ctl_p_r[k].vld <= ctl_p_r[k-1].vld;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      res[k] = ctl_p_r[DIV_LAT-1].sing ? '0 : q[k];
    end
  end

  assign out_strobe      = ctl_p_r[DIV_LAT-1].vld;
  assign out_singular    = ctl_p_r[DIV_LAT-1].sing;
  assign out_determinant = ctl_p_r[DIV_LAT-1].sing ? '0 : detq_p_r[DIV_LAT-1];
  assign out_inv00 = res[0];
  assign out_inv01 = res[1];
  assign out_inv02 = res[2];
  assign out_inv10 = res[3];
  assign out_inv11 = res[4];
  assign out_inv12 = res[5];
  assign out_inv20 = res[6];
  assign out_inv21 = res[7];
  assign out_inv22 = res[8];

endmodule

@@ rtl/mxi_front.sv @@
// Front end of the matrix inverse: cofactors, determinant, magnitudes.
// Six register stages. Depends on mxi_pkg.
module mxi_front #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int CW = 2 * W + 1,
  parameter int DW = 3 * W + 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  vld_i,
  input  logic signed [W-1:0]   m_i [9],
  output mxi_pkg::mxi_ctl_t     ctl_o,
  output logic [DW-1:0]         det_mag_o,
  output logic                  det_neg_o,
  output logic [W-1:0]          det_q_o,
  output logic [CW-1:0]         cof_mag_o [9],
  output logic                  cof_neg_o [9]
);
  import mxi_pkg::*;

  localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};

  logic [FRONT_STAGES-1:0] vld_r;
  logic                    sing_r;

  logic signed [2*W-1:0] p_r [9];
  logic signed [2*W-1:0] t_r [9];
  logic signed [W-1:0]   m0_r1 [3];
  logic signed [W-1:0]   m0_r2 [3];
  logic signed [CW-1:0]  cof_r [9];
  logic signed [CW-1:0]  cof_r3 [9];
  logic signed [CW-1:0]  cof_r4 [9];
  logic signed [CW-1:0]  cof_r5 [9];
  logic signed [2*W:0]   ph_r [3];
  logic signed [2*W:0]   pl_r [3];
  logic signed [DW-1:0]  term_r [3];
  logic signed [DW-1:0]  det_r;

  logic [DW-1:0] det_mag_nxt;
  logic [DW-1:0] det_sh;
  logic [DW-1:0] half_lim;
  logic [W-1:0]  det_q_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_STAGES-2:0], vld_i};
    end
  end

  // stage 1: the 18 minor products
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p_r[r*3+c] <= m_i[((r == 0) ? 1 : 0) * 3 + ((c == 0) ? 1 : 0)] *
                      m_i[((r == 2) ? 1 : 2) * 3 + ((c == 2) ? 1 : 2)];
        t_r[r*3+c] <= m_i[((r == 0) ? 1 : 0) * 3 + ((c == 2) ? 1 : 2)] *
                      m_i[((r == 2) ? 1 : 2) * 3 + ((c == 0) ? 1 : 0)];
      end
    end
    for (int c = 0; c < 3; c++) begin
      m0_r1[c] <= m_i[c];
    end
  end

  // stage 2: cofactors, odd positions take the swapped difference
  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      if (((k / 3 + k % 3) & 1) != 0) begin
        cof_r[k] <= CW'(t_r[k]) - CW'(p_r[k]);
      end else begin
        cof_r[k] <= CW'(p_r[k]) - CW'(t_r[k]);
      end
    end
    m0_r2 <= m0_r1;
  end

  // stage 3: first-row products, cofactor split into signed high / unsigned low half
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      ph_r[c] <= m0_r2[c] * $signed(cof_r[c][CW-1:W]);
      pl_r[c] <= m0_r2[c] * $signed({1'b0, cof_r[c][W-1:0]});
    end
    cof_r3 <= cof_r;
  end

  // stage 4: recombine halves
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      term_r[c] <= (DW'(ph_r[c]) <<< W) + DW'(pl_r[c]);
    end
    cof_r4 <= cof_r3;
  end

  // stage 5: determinant
  always_ff @(posedge clk) begin
    det_r  <= term_r[0] + term_r[1] + term_r[2];
    cof_r5 <= cof_r4;
  end

  // stage 6: magnitudes, signs, scaled determinant
  always_comb begin
    det_mag_nxt = det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
    det_sh      = det_mag_nxt >> (2 * F);
    half_lim    = DW'(1) << (W - 1);
    if (det_r[DW-1]) begin
      det_q_nxt = (det_sh > half_lim) ? MINN : W'(-det_sh[W-1:0]);
    end else begin
      det_q_nxt = (det_sh >= half_lim) ? MAXP : det_sh[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    det_mag_o <= det_mag_nxt;
    det_neg_o <= det_r[DW-1];
    det_q_o   <= det_q_nxt;
    sing_r    <= (det_r == '0);
    for (int k = 0; k < 9; k++) begin
      cof_mag_o[k] <= cof_r5[k][CW-1] ? CW'(-cof_r5[k]) : CW'(cof_r5[k]);
      cof_neg_o[k] <= cof_r5[k][CW-1];
    end
  end

  assign ctl_o = {vld_r[FRONT_STAGES-1], sing_r};

endmodule

@@ rtl/mxi_div.sv @@
// Pipelined restoring divider: (num << 2F) / den, one quotient bit per step stage,
// truncated toward zero and saturated to W bits. Depends on mxi_pkg.
module mxi_div #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int CW = 2 * W + 1,
  parameter int DW = 3 * W + 3
) (
  input  logic          clk,
  input  logic [CW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic          neg_i,
  output logic [W-1:0]  q_o
);
  import mxi_pkg::*;

  localparam int NW   = CW + 2 * F;
  localparam int HW   = NW - W;
  localparam int CMPW = (HW > DW) ? HW : DW;
  localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};

  logic [NW-1:0] n_full;
  logic          ovf;

  logic [DW-1:0] rem_r [W+1];
  logic [W-1:0]  qb_r  [W+1];
  logic [DW-1:0] den_r [W+1];
  logic          neg_r [W+1];
  logic          ovf_r [W+1];

  assign n_full = NW'(num_i) << (2 * F);
  // quotient fits W bits only when the upper part is below the divisor
  assign ovf    = CMPW'(n_full[NW-1:W]) >= CMPW'(den_i);

  always_ff @(posedge clk) begin
    rem_r[0] <= DW'(n_full[NW-1:W]);
    qb_r[0]  <= n_full[W-1:0];
    den_r[0] <= den_i;
    neg_r[0] <= neg_i;
    ovf_r[0] <= ovf;
  end

  for (genvar k = 1; k <= W; k++) begin : g_step
    logic [DW:0] trial;
    logic        take;
    assign trial = {rem_r[k-1], qb_r[k-1][W-1]};
    assign take  = trial >= {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      rem_r[k] <= take ? DW'(trial - {1'b0, den_r[k-1]}) : trial[DW-1:0];
      qb_r[k]  <= {qb_r[k-1][W-2:0], take};
      den_r[k] <= den_r[k-1];
      neg_r[k] <= neg_r[k-1];
      ovf_r[k] <= ovf_r[k-1];
    end
  end

  logic [W-1:0] q_nxt;
  always_comb begin
    if (ovf_r[W]) begin
      q_nxt = neg_r[W] ? MINN : MAXP;
    end else if (neg_r[W]) begin
      q_nxt = (qb_r[W] > MINN) ? MINN : W'(-qb_r[W]);
    end else begin
      q_nxt = qb_r[W][W-1] ? MAXP : qb_r[W];
    end
  end

  always_ff @(posedge clk) begin
    q_o <= q_nxt;
  end

endmodule

@@ rtl/mxi_chk.sv @@
// Port-level checker for matrix3x3_inverse_core, bound to the top level.
// Depends on mxi_pkg only for import style.
module mxi_chk #(
  parameter int W   = 32,
  parameter int LAT = 40
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input logic                out_singular,
  input logic signed [W-1:0] out_inv00,
  input logic signed [W-1:0] out_inv11,
  input logic signed [W-1:0] out_determinant
);
  import mxi_pkg::*;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // a result only appears for an earlier accepted item
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && rst_n, LAT))
    else $error("result without matching item");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_singular) |->
      (out_inv00 == '0 && out_inv11 == '0 && out_determinant == '0))
    else $error("singular result not zeroed");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result right after reset");

endmodule

bind matrix3x3_inverse_core mxi_chk #(.W(DATA_WIDTH), .LAT(DATA_WIDTH + 8)) u_mxi_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_singular    (out_singular),
  .out_inv00       (out_inv00),
  .out_inv11       (out_inv11),
  .out_determinant (out_determinant)
);
